@@ rtl/tspf_pkg.sv @@
package tspf_pkg;

  localparam int POS_W = 18;
  localparam logic [POS_W-1:0] POS_LIMIT = 18'h20000;

  localparam int IP_FIXED_BYTES = 20;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  localparam int TCP_OFF_BYTE = 12;
  localparam int TCP_SUM_HI_BYTE = 16;
  localparam int TCP_SUM_LO_BYTE = 17;
  localparam int IP_SUM_HI_BYTE = 10;
  localparam int IP_SUM_LO_BYTE = 11;

  localparam logic [1:0] CFG_LINK_BYTES = 2'd0;
  localparam logic [1:0] CFG_SIG_LEN    = 2'd1;
  localparam logic [1:0] CFG_SIG_LOW    = 2'd2;
  localparam logic [1:0] CFG_SIG_HIGH   = 2'd3;

  localparam logic [2:0] V_ACCEPT  = 3'd0;
  localparam logic [2:0] V_NOT_TCP = 3'd1;
  localparam logic [2:0] V_LENGTH  = 3'd2;
  localparam logic [2:0] V_IP_SUM  = 3'd3;
  localparam logic [2:0] V_SHORT   = 3'd4;
  localparam logic [2:0] V_TCP_SUM = 3'd5;
  localparam logic [2:0] V_SIG     = 3'd6;

  // per-frame state captured at the last byte
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       ihl;
    logic [15:0]      ip_len;
    logic [7:0]       proto;
    logic [15:0]      ip_csum;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [15:0]      ip_acc;
    logic [15:0]      tcp_acc;
    logic [3:0]       tcp_off;
    logic [15:0]      tcp_rcv;
    logic             sig_ok;
    logic [7:0]       hold;
  } fin_t;

  // check results handed to the verdict stage
  typedef struct packed {
    logic        len_short;
    logic        not_tcp;
    logic        bad_len;
    logic        ip_bad;
    logic        too_short;
    logic        sig_ok;
    logic [15:0] tcp_rcv;
    logic [19:0] tcp_sum;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] hdr_off;
    logic [15:0] payload;
  } chk_t;

  function automatic logic [15:0] sum_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

@@ rtl/tspf_parse.sv @@
module tspf_parse
  import tspf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [6:0]   link_bytes,
  input  logic [4:0]   sig_len,
  input  logic [127:0] sig_bytes,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_frame_byte,
  input  logic         in_last_byte,
  output logic         fin_valid,
  output fin_t         fin,
  input  logic         fin_take
);

  logic             s0_valid_r;
  logic [7:0]       s0_byte_r;
  logic             s0_last_r;
  logic             s0_go;
  logic             f_free;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      word_r [5];
  logic [31:0]      word_nxt [5];
  logic [15:0]      ip_acc_r, ip_acc_nxt;
  logic [15:0]      tcp_acc_r, tcp_acc_nxt;
  logic [3:0]       tcp_off_r, tcp_off_nxt;
  logic [15:0]      tcp_rcv_r, tcp_rcv_nxt;
  logic             sig_ok_r, sig_ok_nxt;
  logic [7:0]       hold_r, hold_nxt;

  logic             fin_valid_r;
  fin_t             fin_r, fin_nxt;

  logic             in_ip, in_iph, in_tcp;
  logic [POS_W-1:0] r, t, k;
  logic [3:0]       ihl_cur;
  logic [5:0]       hl, thl;
  logic [7:0]       v;

  assign f_free   = !fin_valid_r || fin_take;
  assign s0_go    = s0_valid_r && (!s0_last_r || f_free);
  assign in_ready = !s0_valid_r || s0_go;

  always_comb begin
    in_ip   = pos_r >= POS_W'(link_bytes);
    r       = pos_r - POS_W'(link_bytes);
    ihl_cur = (r == '0) ? s0_byte_r[3:0] : word_r[0][27:24];
    hl      = {ihl_cur, 2'b00};
    thl     = {tcp_off_r, 2'b00};
    t       = r - POS_W'(hl);
    k       = t - POS_W'(thl);
    in_iph  = in_ip && (r < POS_W'(hl));
    in_tcp  = in_ip && !in_iph && (ihl_cur >= MIN_HDR_WORDS) &&
              (r < POS_W'(word_r[0][15:0]));

    pos_nxt     = pos_r + POS_W'(pos_r < POS_LIMIT);
    word_nxt    = word_r;
    ip_acc_nxt  = ip_acc_r;
    tcp_acc_nxt = tcp_acc_r;
    tcp_off_nxt = tcp_off_r;
    tcp_rcv_nxt = tcp_rcv_r;
    sig_ok_nxt  = sig_ok_r;
    hold_nxt    = hold_r;
    v           = s0_byte_r;

    if (in_ip && r < POS_W'(IP_FIXED_BYTES)) begin
      word_nxt[r[4:2]][{~r[1:0], 3'b000} +: 8] = s0_byte_r;
    end

    if (in_iph) begin
      if (r == POS_W'(IP_SUM_HI_BYTE) || r == POS_W'(IP_SUM_LO_BYTE)) begin
        v = '0;
      end
      if (!r[0]) begin
        hold_nxt = v;
      end else begin
        ip_acc_nxt = sum_add(ip_acc_r, {hold_r, v});
      end
    end else if (in_tcp) begin
      if (t == POS_W'(TCP_OFF_BYTE)) begin
        tcp_off_nxt = s0_byte_r[7:4];
      end
      if (t == POS_W'(TCP_SUM_HI_BYTE) || t == POS_W'(TCP_SUM_LO_BYTE)) begin
        tcp_rcv_nxt = {tcp_rcv_r[7:0], s0_byte_r};
        v = '0;
      end
      if (!r[0]) begin
        hold_nxt = v;
      end else begin
        tcp_acc_nxt = sum_add(tcp_acc_r, {hold_r, v});
      end
      if (t > POS_W'(TCP_OFF_BYTE) && t >= POS_W'(thl) && k < POS_W'(sig_len) &&
          s0_byte_r != sig_bytes[{k[3:0], 3'b000} +: 8]) begin
        sig_ok_nxt = 1'b0;
      end
    end

    fin_nxt.pos     = pos_nxt;
    fin_nxt.ihl     = word_nxt[0][27:24];
    fin_nxt.ip_len  = word_nxt[0][15:0];
    fin_nxt.proto   = word_nxt[2][23:16];
    fin_nxt.ip_csum = word_nxt[2][15:0];
    fin_nxt.src     = word_nxt[3];
    fin_nxt.dst     = word_nxt[4];
    fin_nxt.ip_acc  = ip_acc_nxt;
    fin_nxt.tcp_acc = tcp_acc_nxt;
    fin_nxt.tcp_off = tcp_off_nxt;
    fin_nxt.tcp_rcv = tcp_rcv_nxt;
    fin_nxt.sig_ok  = sig_ok_nxt;
    fin_nxt.hold    = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s0_byte_r <= in_frame_byte;
      s0_last_r <= in_last_byte;
    end
  end

  // per-frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (s0_go && s0_last_r)) begin
      pos_r     <= '0;
      for (int i = 0; i < 5; i++) begin
        word_r[i] <= '0;
      end
      ip_acc_r  <= '0;
      tcp_acc_r <= '0;
      tcp_off_r <= '0;
      tcp_rcv_r <= '0;
      sig_ok_r  <= 1'b1;
      hold_r    <= '0;
    end else if (s0_go) begin
      pos_r     <= pos_nxt;
      word_r    <= word_nxt;
      ip_acc_r  <= ip_acc_nxt;
      tcp_acc_r <= tcp_acc_nxt;
      tcp_off_r <= tcp_off_nxt;
      tcp_rcv_r <= tcp_rcv_nxt;
      sig_ok_r  <= sig_ok_nxt;
      hold_r    <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (f_free) begin
      fin_valid_r <= s0_go && s0_last_r;
    end
    if (f_free && s0_go && s0_last_r) begin
      fin_r <= fin_nxt;
    end
  end

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

endmodule

@@ rtl/tspf_check.sv @@
module tspf_check
  import tspf_pkg::*;
#(
  parameter int TUNNEL_HEADER_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [6:0] link_bytes,
  input  logic [4:0] sig_len,
  input  logic       fin_valid,
  input  fin_t       fin,
  output logic       fin_take,
  output logic       chk_valid,
  output chk_t       chk,
  input  logic       chk_take
);

  logic               chk_valid_r;
  chk_t               chk_r, chk_nxt;
  logic [POS_W-1:0]   link18, hl18, thl18, n;
  logic signed [POS_W-1:0] avail, need;
  logic [15:0]        tcp_len, odd_word, hl16, thl16;

  assign fin_take = !chk_valid_r || chk_take;

  always_comb begin
    n       = fin.pos;
    link18  = POS_W'(link_bytes);
    hl18    = POS_W'({fin.ihl, 2'b00});
    thl18   = POS_W'({fin.tcp_off, 2'b00});
    hl16    = 16'({fin.ihl, 2'b00});
    thl16   = 16'({fin.tcp_off, 2'b00});
    avail   = $signed(POS_W'(fin.ip_len)) - $signed(hl18) - $signed(thl18);
    need    = $signed(POS_W'(sig_len) + POS_W'(TUNNEL_HEADER_BYTES));
    tcp_len = fin.ip_len - hl16;
    odd_word = tcp_len[0] ? {fin.hold, 8'h00} : 16'h0000;

    chk_nxt.len_short = n < link18 + POS_W'(IP_FIXED_BYTES);
    chk_nxt.not_tcp   = fin.proto != PROTO_TCP;
    chk_nxt.bad_len   = (fin.ihl < MIN_HDR_WORDS) ||
                        (n < link18 + hl18 + POS_W'(IP_FIXED_BYTES)) ||
                        (fin.tcp_off < MIN_HDR_WORDS) ||
                        (n < link18 + hl18 + thl18) ||
                        (link18 + POS_W'(fin.ip_len) > n);
    chk_nxt.ip_bad    = ~fin.ip_acc != fin.ip_csum;
    chk_nxt.too_short = avail < need;
    chk_nxt.sig_ok    = fin.sig_ok;
    chk_nxt.tcp_rcv   = fin.tcp_rcv;
    chk_nxt.tcp_sum   = 20'(fin.tcp_acc) + 20'(odd_word) +
                        20'(fin.src[31:16]) + 20'(fin.src[15:0]) +
                        20'(fin.dst[31:16]) + 20'(fin.dst[15:0]) +
                        20'(PROTO_TCP) + 20'(tcp_len);
    chk_nxt.src       = fin.src;
    chk_nxt.dst       = fin.dst;
    chk_nxt.hdr_off   = 16'(link_bytes) + hl16 + thl16 + 16'(sig_len);
    chk_nxt.payload   = avail[15:0] - need[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else if (fin_take) begin
      chk_valid_r <= fin_valid;
    end
    if (fin_take && fin_valid) begin
      chk_r <= chk_nxt;
    end
  end

  assign chk_valid = chk_valid_r;
  assign chk       = chk_r;

endmodule

@@ rtl/tspf_verdict.sv @@
module tspf_verdict
  import tspf_pkg::*;
#(
  parameter int TUNNEL_HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        chk_valid,
  input  chk_t        chk,
  output logic        chk_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_header_offset,
  output logic [15:0] out_payload_length,
  output logic [63:0] out_received_total
);

  logic        out_valid_r;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [31:0] src_r, dst_r;
  logic [15:0] hdr_off_r, payload_r;
  logic [63:0] total_r, total_nxt, rep_total_r;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        tcp_bad, load;

  assign chk_take = !out_valid_r || out_ready;
  assign load     = chk_take && chk_valid;

  always_comb begin
    fold1   = {1'b0, chk.tcp_sum[15:0]} + 17'(chk.tcp_sum[19:16]);
    fold2   = fold1[15:0] + 16'(fold1[16]);
    tcp_bad = ~fold2 != chk.tcp_rcv;

    if (chk.len_short) begin
      verdict_nxt = V_LENGTH;
    end else if (chk.not_tcp) begin
      verdict_nxt = V_NOT_TCP;
    end else if (chk.bad_len) begin
      verdict_nxt = V_LENGTH;
    end else if (chk.ip_bad) begin
      verdict_nxt = V_IP_SUM;
    end else if (chk.too_short) begin
      verdict_nxt = V_SHORT;
    end else if (tcp_bad) begin
      verdict_nxt = V_TCP_SUM;
    end else if (!chk.sig_ok) begin
      verdict_nxt = V_SIG;
    end else begin
      verdict_nxt = V_ACCEPT;
    end

    total_nxt = total_r + 64'(chk.payload) + 64'(TUNNEL_HEADER_BYTES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (chk_take) begin
        out_valid_r <= chk_valid;
      end
      if (load && verdict_nxt == V_ACCEPT) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict_nxt;
      if (verdict_nxt == V_ACCEPT) begin
        src_r       <= chk.src;
        dst_r       <= chk.dst;
        hdr_off_r   <= chk.hdr_off;
        payload_r   <= chk.payload;
        rep_total_r <= total_nxt;
      end else begin
        src_r       <= '0;
        dst_r       <= '0;
        hdr_off_r   <= '0;
        payload_r   <= '0;
        rep_total_r <= total_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_source_address = src_r;
  assign out_dest_address   = dst_r;
  assign out_header_offset  = hdr_off_r;
  assign out_payload_length = payload_r;
  assign out_received_total = rep_total_r;

endmodule

@@ rtl/tcp_signature_packet_filter.sv @@
// channel  | handshake           | payload
// in       | in_valid/in_ready   | in_frame_byte, in_last_byte
// out      | out_valid/out_ready | out_verdict, addresses, offset, length, total
// cfg      | cfg_wr_en           | cfg_index, cfg_wdata
//
// one frame byte per cycle while the pipe is not full, sustained across frame boundaries
// after its last byte is taken, a verdict passes through the
// input register, frame-state capture, checks and output register
// sync active-low reset clears all pipeline valids, frame state and the byte total
// each stage holds while the one after it is full, so in_ready drops only on a full pipe
module tcp_signature_packet_filter
  import tspf_pkg::*;
#(
  parameter int TUNNEL_HEADER_BYTES = 8,
  parameter int MAX_SIGNATURE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_header_offset,
  output logic [15:0] out_payload_length,
  output logic [63:0] out_received_total
);

  logic [6:0]  link_r;
  logic [4:0]  sig_len_r, sig_len_nxt;
  logic [63:0] sig_low_r, sig_high_r;

  logic        fin_valid, fin_take;
  fin_t        fin;
  logic        chk_valid, chk_take;
  chk_t        chk;

  assign sig_len_nxt = (cfg_wdata[4:0] > 5'(MAX_SIGNATURE_BYTES)) ?
                       5'(MAX_SIGNATURE_BYTES) : cfg_wdata[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r     <= 7'd14;
      sig_len_r  <= '0;
      sig_low_r  <= '0;
      sig_high_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LINK_BYTES: link_r     <= cfg_wdata[6:0];
        CFG_SIG_LEN:    sig_len_r  <= sig_len_nxt;
        CFG_SIG_LOW:    sig_low_r  <= cfg_wdata;
        CFG_SIG_HIGH:   sig_high_r <= cfg_wdata;
        default:        link_r     <= link_r;
      endcase
    end
  end

  tspf_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .link_bytes    (link_r),
    .sig_len       (sig_len_r),
    .sig_bytes     ({sig_high_r, sig_low_r}),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_frame_byte (in_frame_byte),
    .in_last_byte  (in_last_byte),
    .fin_valid     (fin_valid),
    .fin           (fin),
    .fin_take      (fin_take)
  );

  tspf_check #(
    .TUNNEL_HEADER_BYTES (TUNNEL_HEADER_BYTES)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_bytes (link_r),
    .sig_len    (sig_len_r),
    .fin_valid  (fin_valid),
    .fin        (fin),
    .fin_take   (fin_take),
    .chk_valid  (chk_valid),
    .chk        (chk),
    .chk_take   (chk_take)
  );

  tspf_verdict #(
    .TUNNEL_HEADER_BYTES (TUNNEL_HEADER_BYTES)
  ) u_verdict (
    .clk                (clk),
    .rst_n              (rst_n),
    .chk_valid          (chk_valid),
    .chk                (chk),
    .chk_take           (chk_take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_header_offset  (out_header_offset),
    .out_payload_length (out_payload_length),
    .out_received_total (out_received_total)
  );

endmodule
